FILE: rtl/fixed_priority_ready_queue_core_defines.svh
// Assertion macros used by the ready queue checker
`ifndef FIXED_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`define FIXED_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define FPRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fprq: check failed");

// Next-cycle implication, disabled while reset is held
`define FPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fprq: check failed");

`endif

FILE: rtl/fprq_pkg.sv
// Request codes, error codes and shared types of the ready queue
package fprq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_DEQUEUE = 2'd1,
    FUNC_PICK    = 2'd2,
    FUNC_TICK    = 2'd3
  } fprq_func_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_ABSENT  = 2'd2,
    ERR_PRESENT = 2'd3
  } fprq_err_e;

  // Flags returned by the shared compare unit
  typedef struct packed {
    logic id_eq;
    logic prio_gt;
  } fprq_cmp_t;

endpackage

FILE: rtl/fprq_if.sv
// Request and response channel interfaces of the ready queue
interface fprq_req_if #(
  parameter int TASK_ID_BITS  = 6,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [TASK_ID_BITS-1:0]  task_id;
  logic [PRIORITY_BITS-1:0] task_priority;
  logic                     current_is_idle;

  modport source (output valid, func, task_id, task_priority, current_is_idle,
                  input ready);
  modport sink (input valid, func, task_id, task_priority, current_is_idle,
                output ready);
endinterface

interface fprq_rsp_if #(
  parameter int TASK_ID_BITS = 6,
  parameter int COUNT_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic                    picked_valid;
  logic [TASK_ID_BITS-1:0] picked_id;
  logic                    resched_req;
  logic [COUNT_BITS-1:0]   queued_count;
  logic [1:0]              error;

  modport source (output valid, picked_valid, picked_id, resched_req, queued_count,
                  error, input ready);
  modport sink (input valid, picked_valid, picked_id, resched_req, queued_count,
                error, output ready);
endinterface

FILE: rtl/fixed_priority_ready_queue_core.sv
// Fixed-priority ready queue: slot memory, shared compare unit and request sequencer
//
//   channel  dir  modport  carries
//   req_i    in   sink     func, task_id, task_priority, current_is_idle
//   rsp_o    out  source   picked_valid, picked_id, resched_req, queued_count, error
//
// Steps: enqueue, pick and tick walk the queued slots once from the head to
// the result register; dequeue, on a match, walks the slots behind it again
// to close the gap. The single read port of the slot memory sets this: one
// slot is read per cycle. One transaction at a time.
// Reset clears all registers but not the slots, which are written before read.
// A stalled result holds in the output register; the next request is taken
// as soon as the result has been loaded, whether or not it has been taken.
module fixed_priority_ready_queue_core
  import fprq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TASK_ID_BITS  = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fprq_req_if.sink   req_i,
  fprq_rsp_if.source rsp_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TASK_ID_BITS + PRIORITY_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                   state_q, state_d;
  fprq_func_e               func_q, func_d;
  logic [TASK_ID_BITS-1:0]  id_q, id_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                     idle_q, idle_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            raddr_q, raddr_d;     // next slot to read
  logic                     tag_vld_q, tag_vld_d; // read data valid this cycle
  logic [AW-1:0]            tag_addr_q, tag_addr_d;
  logic                     found_q, found_d;     // match, pick hit or preempt
  logic [AW-1:0]            pos_q, pos_d;
  logic [PRIORITY_BITS-1:0] best_q, best_d;
  logic [TASK_ID_BITS-1:0]  pick_id_q, pick_id_d;

  // Output register
  logic                     rsp_vld_q, rsp_vld_d;
  logic                     rsp_pvld_q, rsp_pvld_d;
  logic [TASK_ID_BITS-1:0]  rsp_pid_q, rsp_pid_d;
  logic                     rsp_resched_q, rsp_resched_d;
  logic [CW-1:0]            rsp_count_q, rsp_count_d;
  fprq_err_e                rsp_err_q, rsp_err_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [EW-1:0]            ram_rdata;
  logic [TASK_ID_BITS-1:0]  entry_id;
  logic [PRIORITY_BITS-1:0] entry_prio;
  fprq_cmp_t                cmp;
  logic                     out_free;
  logic                     queue_full;
  logic                     enq_ok;

  assign entry_id   = ram_rdata[EW-1:PRIORITY_BITS];
  assign entry_prio = ram_rdata[PRIORITY_BITS-1:0];

  fprq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  fprq_cmp_unit #(
    .TASK_ID_BITS  (TASK_ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_cmp_unit (
    .entry_id_i   (entry_id),
    .entry_prio_i (entry_prio),
    .key_id_i     (id_q),
    .req_prio_i   (prio_q),
    .best_prio_i  (best_q),
    .sel_best_i   (func_q == FUNC_PICK),
    .cmp_o        (cmp)
  );

  assign out_free   = !rsp_vld_q || rsp_o.ready;
  assign queue_full = (count_q == CW'(QUEUE_DEPTH));
  assign enq_ok     = (func_q == FUNC_ENQUEUE) && !found_q && !queue_full;

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    id_d          = id_q;
    prio_d        = prio_q;
    idle_d        = idle_q;
    count_d       = count_q;
    raddr_d       = raddr_q;
    tag_vld_d     = 1'b0;
    tag_addr_d    = tag_addr_q;
    found_d       = found_q;
    pos_d         = pos_q;
    best_d        = best_q;
    pick_id_d     = pick_id_q;
    rsp_vld_d     = rsp_vld_q && !rsp_o.ready;
    rsp_pvld_d    = rsp_pvld_q;
    rsp_pid_d     = rsp_pid_q;
    rsp_resched_d = rsp_resched_q;
    rsp_count_d   = rsp_count_q;
    rsp_err_d     = rsp_err_q;
    // Shift path writes each slot one place lower; enqueue overrides below
    ram_we        = 1'b0;
    ram_waddr     = tag_addr_q - AW'(1);
    ram_wdata     = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          // Latch the request and start the walk from the head
          func_d  = fprq_func_e'(req_i.func);
          id_d    = req_i.task_id;
          prio_d  = req_i.task_priority;
          idle_d  = req_i.current_is_idle;
          found_d = 1'b0;
          best_d  = '0;
          raddr_d = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (raddr_q != count_q) begin
          tag_vld_d  = 1'b1;
          tag_addr_d = raddr_q[AW-1:0];
          raddr_d    = raddr_q + CW'(1);
        end
        if (tag_vld_q) begin
          case (func_q)
            FUNC_PICK: begin
              // Strictly greater keeps the earliest arrival on ties
              if (!found_q || cmp.prio_gt) begin
                found_d   = 1'b1;
                best_d    = entry_prio;
                pick_id_d = entry_id;
              end
            end
            FUNC_TICK: begin
              if (cmp.prio_gt) begin
                found_d = 1'b1;
              end
            end
            default: begin
              if (cmp.id_eq && !found_q) begin
                found_d = 1'b1;
                pos_d   = tag_addr_q;
              end
            end
          endcase
        end
        if ((raddr_q == count_q) && !tag_vld_q) begin
          if ((func_q == FUNC_DEQUEUE) && found_q) begin
            raddr_d = CW'(pos_q) + CW'(1);
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // Read slot k, write it back at k - 1 in the following cycle
        if (raddr_q != count_q) begin
          tag_vld_d  = 1'b1;
          tag_addr_d = raddr_q[AW-1:0];
          raddr_d    = raddr_q + CW'(1);
        end
        if (tag_vld_q) begin
          ram_we = 1'b1;
        end
        if ((raddr_q == count_q) && !tag_vld_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          if (enq_ok) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = {id_q, prio_q};
            count_d   = count_q + CW'(1);
          end else if ((func_q == FUNC_DEQUEUE) && found_q) begin
            count_d = count_q - CW'(1);
          end
          rsp_vld_d     = 1'b1;
          rsp_pvld_d    = (func_q == FUNC_PICK) && found_q;
          rsp_pid_d     = ((func_q == FUNC_PICK) && found_q) ? pick_id_q : '0;
          rsp_resched_d = (func_q == FUNC_TICK) && (idle_q || found_q);
          rsp_count_d   = count_d;
          case (func_q)
            FUNC_ENQUEUE: rsp_err_d = found_q ? ERR_PRESENT : (queue_full ? ERR_FULL : ERR_OK);
            FUNC_DEQUEUE: rsp_err_d = found_q ? ERR_OK : ERR_ABSENT;
            default:      rsp_err_d = ERR_OK;
          endcase
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      func_q        <= FUNC_ENQUEUE;
      id_q          <= '0;
      prio_q        <= '0;
      idle_q        <= 1'b0;
      count_q       <= '0;
      raddr_q       <= '0;
      tag_vld_q     <= 1'b0;
      tag_addr_q    <= '0;
      found_q       <= 1'b0;
      pos_q         <= '0;
      best_q        <= '0;
      pick_id_q     <= '0;
      rsp_vld_q     <= 1'b0;
      rsp_pvld_q    <= 1'b0;
      rsp_pid_q     <= '0;
      rsp_resched_q <= 1'b0;
      rsp_count_q   <= '0;
      rsp_err_q     <= ERR_OK;
    end else begin
      state_q       <= state_d;
      func_q        <= func_d;
      id_q          <= id_d;
      prio_q        <= prio_d;
      idle_q        <= idle_d;
      count_q       <= count_d;
      raddr_q       <= raddr_d;
      tag_vld_q     <= tag_vld_d;
      tag_addr_q    <= tag_addr_d;
      found_q       <= found_d;
      pos_q         <= pos_d;
      best_q        <= best_d;
      pick_id_q     <= pick_id_d;
      rsp_vld_q     <= rsp_vld_d;
      rsp_pvld_q    <= rsp_pvld_d;
      rsp_pid_q     <= rsp_pid_d;
      rsp_resched_q <= rsp_resched_d;
      rsp_count_q   <= rsp_count_d;
      rsp_err_q     <= rsp_err_d;
    end
  end

  // Take a request only between transactions
  assign req_i.ready        = (state_q == S_IDLE);

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.picked_valid = rsp_pvld_q;
  assign rsp_o.picked_id    = rsp_pid_q;
  assign rsp_o.resched_req  = rsp_resched_q;
  assign rsp_o.queued_count = rsp_count_q;
  assign rsp_o.error        = rsp_err_q;

endmodule

FILE: rtl/fprq_slot_ram.sv
// Slot memory: one write port, one registered read port
module fprq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 14
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fprq_cmp_unit.sv
// Shared compare unit: id match and strict priority compare against a chosen reference
module fprq_cmp_unit
  import fprq_pkg::*;
#(
  parameter int TASK_ID_BITS  = 6,
  parameter int PRIORITY_BITS = 8
) (
  input  logic [TASK_ID_BITS-1:0]  entry_id_i,
  input  logic [PRIORITY_BITS-1:0] entry_prio_i,
  input  logic [TASK_ID_BITS-1:0]  key_id_i,
  input  logic [PRIORITY_BITS-1:0] req_prio_i,
  input  logic [PRIORITY_BITS-1:0] best_prio_i,
  input  logic                     sel_best_i,
  output fprq_cmp_t                cmp_o
);

  logic [PRIORITY_BITS-1:0] ref_prio;

  // Compare against the running best on pick, the request priority otherwise
  assign ref_prio      = sel_best_i ? best_prio_i : req_prio_i;
  assign cmp_o.id_eq   = (entry_id_i == key_id_i);
  assign cmp_o.prio_gt = (entry_prio_i > ref_prio);

endmodule

FILE: rtl/fprq_checker.sv
// Port-level checks of the ready queue and their binding to the top level
`include "fixed_priority_ready_queue_core_defines.svh"

module fprq_checker
  import fprq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 6
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic                             picked_valid_i,
  input logic [TASK_ID_BITS-1:0]          picked_id_i,
  input logic                             resched_req_i,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] queued_count_i,
  input logic [1:0]                       error_i
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // One transaction at a time: after acceptance the request side closes
  `FPRQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // A successful pick never carries an error or a reschedule request
  `FPRQ_ASSERT_NOW(a_pick_clean, clk_i, rst_ni, rsp_valid_i && picked_valid_i, (error_i == ERR_OK) && !resched_req_i)

  // Any response without a picked task reports id zero
  `FPRQ_ASSERT_NOW(a_empty_pick_id, clk_i, rst_ni, rsp_valid_i && !picked_valid_i, picked_id_i == '0)

  // The count never exceeds the queue depth
  `FPRQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, rsp_valid_i, queued_count_i <= CW'(QUEUE_DEPTH))

  // A stalled result holds
  `FPRQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(queued_count_i) && $stable(error_i))

endmodule

bind fixed_priority_ready_queue_core fprq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .TASK_ID_BITS (TASK_ID_BITS)
) u_fprq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .picked_valid_i (rsp_o.picked_valid),
  .picked_id_i    (rsp_o.picked_id),
  .resched_req_i  (rsp_o.resched_req),
  .queued_count_i (rsp_o.queued_count),
  .error_i        (rsp_o.error)
);
